// ===== hdl/kars_pkg.sv =====
// Shared types, register indexes and reset constants for the key-to-axis ramp unit.
// No dependencies; every other file of the block imports this package.
package kars_pkg;

  localparam int AXIS_FULL_SCALE_DEF = 16384;

  localparam int RATE_W    = 20;
  localparam int DT_W      = 16;
  localparam int STEP_W    = 20;
  localparam int CALC_W    = 22;
  localparam int STEER_W   = 16;
  localparam int PEDAL_W   = 15;
  localparam int GEAR_W    = 5;
  localparam int GLIM_W    = 4;
  localparam int BUTTON_W  = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [RATE_W-1:0] TURN_RATE_RST      = 20'd32768;
  localparam logic [RATE_W-1:0] CENTERING_RATE_RST = 20'd32768;
  localparam logic [RATE_W-1:0] PRESS_RATE_RST     = 20'd32768;
  localparam logic [RATE_W-1:0] RELEASE_RATE_RST   = 20'd32768;
  localparam logic [GLIM_W-1:0] LOWEST_GEAR_RST    = 4'b1111;
  localparam logic [GLIM_W-1:0] HIGHEST_GEAR_RST   = 4'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_RATE      = 3'd0,
    REG_CENTERING_RATE = 3'd1,
    REG_PRESS_RATE     = 3'd2,
    REG_RELEASE_RATE   = 3'd3,
    REG_LOWEST_GEAR    = 3'd4,
    REG_HIGHEST_GEAR   = 3'd5
  } kars_reg_e;

  typedef struct packed {
    logic signed [GLIM_W-1:0] lowest_gear;
    logic        [GLIM_W-1:0] highest_gear;
  } kars_gear_cfg_t;

  typedef struct packed {
    logic up;
    logic down;
  } kars_shift_t;

endpackage

// ===== hdl/key_to_axis_ramp_with_gear_stepper_unit.sv =====
// Key-to-axis ramp unit with gear stepper: top level with input and result registers.
// An accepted input beat passes through the input register, then the ramp, clamp and gear logic
// feeding the result register. Throughput is one beat per cycle while m_axis_tready does not stall
// the output, set by the single state update per tick. Reset clears the axes, the gear and the
// edge detectors to zero and loads the configuration registers with their reset values.
// Depends on kars_pkg, kars_step, kars_steer, kars_pedal and kars_gear.
module key_to_axis_ramp_with_gear_stepper_unit import kars_pkg::*; #(
  parameter int AXIS_FULL_SCALE = AXIS_FULL_SCALE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RATE_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // dt_ticks[15:0], left_key[16], right_key[17], throttle_key[18], brake_key[19],
  // clutch_key[20], up_key[21], down_key[22], button_keys[29:23], zeros above.
  input  logic [31:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // steer_out[15:0], throttle_out[30:16], brake_out[45:31], clutch_out[60:46],
  // paddle_up[61], paddle_down[62], gear_out[67:63], button_bits[74:68], zeros above.
  output logic [79:0]          m_axis_tdata
);

  localparam int AxisLimit = (AXIS_FULL_SCALE > 32767) ? 32767 : AXIS_FULL_SCALE;
  localparam int InW  = DT_W + 7 + BUTTON_W;
  localparam int OutW = STEER_W + 3 * PEDAL_W + 2 + GEAR_W + BUTTON_W;

  logic [RATE_W-1:0] turn_rate_q, centering_rate_q, press_rate_q, release_rate_q;
  kars_gear_cfg_t    gear_cfg_q;

  logic            in_valid_q, out_valid_q, advance;
  logic [InW-1:0]  in_data_q;
  logic [OutW-1:0] out_data_q, out_data_d;

  logic [DT_W-1:0]     dt;
  logic [BUTTON_W-1:0] buttons;
  kars_shift_t         shift;
  logic [STEP_W-1:0]   steer_step, center_step, press_step, release_step;

  logic signed [STEER_W-1:0] steer_pos;
  logic [PEDAL_W-1:0]        throttle_pos, brake_pos, clutch_pos;
  logic signed [GEAR_W-1:0]  gear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_rate_q      <= TURN_RATE_RST;
      centering_rate_q <= CENTERING_RATE_RST;
      press_rate_q     <= PRESS_RATE_RST;
      release_rate_q   <= RELEASE_RATE_RST;
      gear_cfg_q.lowest_gear  <= LOWEST_GEAR_RST;
      gear_cfg_q.highest_gear <= HIGHEST_GEAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TURN_RATE:      turn_rate_q      <= cfg_data_i;
        REG_CENTERING_RATE: centering_rate_q <= cfg_data_i;
        REG_PRESS_RATE:     press_rate_q     <= cfg_data_i;
        REG_RELEASE_RATE:   release_rate_q   <= cfg_data_i;
        REG_LOWEST_GEAR:    gear_cfg_q.lowest_gear  <= cfg_data_i[GLIM_W-1:0];
        REG_HIGHEST_GEAR:   gear_cfg_q.highest_gear <= cfg_data_i[GLIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata[InW-1:0];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign dt         = in_data_q[DT_W-1:0];
  assign shift.up   = in_data_q[21];
  assign shift.down = in_data_q[22];
  assign buttons    = in_data_q[InW-1:23];

  kars_step u_steer_step (
    .rate_i(turn_rate_q), .dt_i(dt), .step_o(steer_step)
  );
  kars_step u_center_step (
    .rate_i(centering_rate_q), .dt_i(dt), .step_o(center_step)
  );
  kars_step u_press_step (
    .rate_i(press_rate_q), .dt_i(dt), .step_o(press_step)
  );
  kars_step u_release_step (
    .rate_i(release_rate_q), .dt_i(dt), .step_o(release_step)
  );

  kars_steer #(.AxisLimit(AxisLimit)) u_steer (
    .clk_i, .rst_ni, .en_i(advance),
    .left_i(in_data_q[16]), .right_i(in_data_q[17]),
    .steer_step_i(steer_step), .center_step_i(center_step),
    .pos_o(steer_pos)
  );

  kars_pedal #(.AxisLimit(AxisLimit)) u_throttle (
    .clk_i, .rst_ni, .en_i(advance), .held_i(in_data_q[18]),
    .press_step_i(press_step), .release_step_i(release_step), .pos_o(throttle_pos)
  );
  kars_pedal #(.AxisLimit(AxisLimit)) u_brake (
    .clk_i, .rst_ni, .en_i(advance), .held_i(in_data_q[19]),
    .press_step_i(press_step), .release_step_i(release_step), .pos_o(brake_pos)
  );
  kars_pedal #(.AxisLimit(AxisLimit)) u_clutch (
    .clk_i, .rst_ni, .en_i(advance), .held_i(in_data_q[20]),
    .press_step_i(press_step), .release_step_i(release_step), .pos_o(clutch_pos)
  );

  kars_gear u_gear (
    .clk_i, .rst_ni, .en_i(advance), .shift_i(shift), .cfg_i(gear_cfg_q), .gear_o(gear)
  );

  assign out_data_d = {buttons, gear, shift.down, shift.up,
                       clutch_pos, brake_pos, throttle_pos, steer_pos};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(80-OutW){1'b0}}, out_data_q};

endmodule

// ===== hdl/kars_step.sv =====
// Ramp step of one rate: (rate * dt) >> 16.
// Depends on kars_pkg for the field widths.
module kars_step import kars_pkg::*; (
  input  logic [RATE_W-1:0] rate_i,
  input  logic [DT_W-1:0]   dt_i,
  output logic [STEP_W-1:0] step_o
);

  logic [RATE_W+DT_W-1:0] prod;

  assign prod   = rate_i * dt_i;
  assign step_o = prod[RATE_W+DT_W-1:DT_W];

endmodule

// ===== hdl/kars_steer.sv =====
// Steering axis state: ramps with the steer keys, centers otherwise, clamps to the limit.
// Depends on kars_pkg for the field and arithmetic widths.
module kars_steer import kars_pkg::*; #(
  parameter int AxisLimit = AXIS_FULL_SCALE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      left_i,
  input  logic                      right_i,
  input  logic [STEP_W-1:0]         steer_step_i,
  input  logic [STEP_W-1:0]         center_step_i,
  output logic signed [STEER_W-1:0] pos_o
);

  localparam logic signed [CALC_W-1:0] LimS = CALC_W'(AxisLimit);

  logic signed [STEER_W-1:0] pos_q, pos_d;
  logic signed [CALC_W-1:0]  cur, ss, cs, v, vc;

  assign cur = {{(CALC_W-STEER_W){pos_q[STEER_W-1]}}, pos_q};
  assign ss  = {{(CALC_W-STEP_W){1'b0}}, steer_step_i};
  assign cs  = {{(CALC_W-STEP_W){1'b0}}, center_step_i};

  always_comb begin
    if (left_i && !right_i) begin
      v = cur - ss;
    end else if (right_i && !left_i) begin
      v = cur + ss;
    end else if (cur > cs) begin
      v = cur - cs;
    end else if (cur < -cs) begin
      v = cur + cs;
    end else begin
      v = '0;
    end
    if (v < -LimS) begin
      vc = -LimS;
    end else if (v > LimS) begin
      vc = LimS;
    end else begin
      vc = v;
    end
    pos_d = vc[STEER_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (en_i) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_d;

endmodule

// ===== hdl/kars_pedal.sv =====
// One pedal axis state: rises by the press step while held, falls by the release step.
// Depends on kars_pkg for the field and arithmetic widths.
module kars_pedal import kars_pkg::*; #(
  parameter int AxisLimit = AXIS_FULL_SCALE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               held_i,
  input  logic [STEP_W-1:0]  press_step_i,
  input  logic [STEP_W-1:0]  release_step_i,
  output logic [PEDAL_W-1:0] pos_o
);

  localparam logic signed [CALC_W-1:0] LimS = CALC_W'(AxisLimit);

  logic [PEDAL_W-1:0]       pos_q, pos_d;
  logic signed [CALC_W-1:0] cur, v, vc;

  assign cur = {{(CALC_W-PEDAL_W){1'b0}}, pos_q};

  always_comb begin
    if (held_i) begin
      v = cur + {{(CALC_W-STEP_W){1'b0}}, press_step_i};
    end else begin
      v = cur - {{(CALC_W-STEP_W){1'b0}}, release_step_i};
    end
    if (v < 0) begin
      vc = '0;
    end else if (v > LimS) begin
      vc = LimS;
    end else begin
      vc = v;
    end
    pos_d = vc[PEDAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (en_i) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_d;

endmodule

// ===== hdl/kars_gear.sv =====
// Gear stepper: steps on rising edges of the shift keys within the configured limits.
// Depends on kars_pkg for the shift and limit structs.
module kars_gear import kars_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  kars_shift_t              shift_i,
  input  kars_gear_cfg_t           cfg_i,
  output logic signed [GEAR_W-1:0] gear_o
);

  logic signed [GEAR_W-1:0] gear_q, gear_d, gear_up, hi5, lo5;
  kars_shift_t              held_q;

  assign hi5 = {1'b0, cfg_i.highest_gear};
  assign lo5 = {cfg_i.lowest_gear[GLIM_W-1], cfg_i.lowest_gear};

  always_comb begin
    gear_up = gear_q;
    if (shift_i.up && !held_q.up && (gear_q < hi5)) begin
      gear_up = gear_q + GEAR_W'(1);
    end
    gear_d = gear_up;
    if (shift_i.down && !held_q.down && (gear_up > lo5)) begin
      gear_d = gear_up - GEAR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q <= '0;
      held_q <= '0;
    end else if (en_i) begin
      gear_q <= gear_d;
      held_q <= shift_i;
    end
  end

  assign gear_o = gear_d;

endmodule
